FILE: hdl/rdm_pkg.sv
`default_nettype none

package rdm_pkg;

   // Fixed field widths of the channels and registers.
   localparam int X_W        = 10;
   localparam int Y_W        = 9;
   localparam int CH_W       = 8;
   localparam int PIX_W      = 3 * CH_W;
   localparam int GAIN_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Offset from the center fits 11 bits signed, its squared radius 21 bits.
   localparam int T_W  = X_W + 1;
   localparam int RT_W = 21;
   // Radial factor 1 + k*rt in Q32.
   localparam int M_W  = 54;
   localparam logic signed [M_W-1:0] M_ONE = M_W'(64'h1_0000_0000);

   localparam logic [GAIN_W-1:0] GAIN_X_RST = '0;
   localparam logic [GAIN_W-1:0] GAIN_Y_RST = '0;
   localparam logic [X_W-1:0]    CENTER_X_RST = X_W'(160);
   localparam logic [Y_W-1:0]    CENTER_Y_RST = Y_W'(240);
   localparam logic [X_W-1:0]    ACTIVE_W_RST = X_W'(320);
   localparam logic [Y_W-1:0]    ACTIVE_H_RST = Y_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_X,
      CSR_GAIN_Y,
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_ACTIVE_WIDTH,
      CSR_ACTIVE_HEIGHT
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_SAMPLE = 1'b1
   } action_type;

   typedef struct packed {
      logic [X_W-1:0]  x;
      logic [Y_W-1:0]  y;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/rdm_req_if.sv
`default_nettype none

interface rdm_req_if import rdm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [X_W-1:0]   pos_x;
   logic [Y_W-1:0]   pos_y;
   logic [CH_W-1:0]  in_blue;
   logic [CH_W-1:0]  in_green;
   logic [CH_W-1:0]  in_red;

   modport source (output valid, action, pos_x, pos_y, in_blue, in_green, in_red,
                   input ready);
   modport sink   (input valid, action, pos_x, pos_y, in_blue, in_green, in_red,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/rdm_rsp_if.sv
`default_nettype none

interface rdm_rsp_if import rdm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [X_W-1:0]   out_x;
   logic [Y_W-1:0]   out_y;
   logic [CH_W-1:0]  out_blue;
   logic [CH_W-1:0]  out_green;
   logic [CH_W-1:0]  out_red;

   modport source (output valid, out_x, out_y, out_blue, out_green, out_red,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_blue, out_green, out_red,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/rdm_ram.sv
`default_nettype none

module rdm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 76800
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/radial_distortion_remap_top.sv
`default_nettype none

// Radial lens distortion remap with bilinear sampling. Load items write one BGR
// pixel into a frame store; sample items return the pixel seen at the distorted
// source position of (pos_x, pos_y), interpolated from four neighbours, with
// neighbours outside the active frame taken as black. The block takes one item
// per clock while the output skid register is empty. The frame store is split
// into four banks by row and column parity, so the four neighbours of any
// position sit in four different banks and are read in the same cycle; loads
// write the same banks at the same pipeline stage, so every item sees all
// loads accepted before it. Ready drops only after two results are waiting at
// the output. The store is not cleared at reset: sample only positions whose
// neighbours inside the active frame have been loaded. The user must write
// registers only while no item is in flight; the block does not enforce it.
module radial_distortion_remap_top import rdm_pkg::*; #(
   parameter int FRAME_WIDTH   = 640,
   parameter int FRAME_HEIGHT  = 480,
   parameter int SUBPIXEL_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rdm_req_if.sink                    req_chan,
   rdm_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int HALF_W     = (FRAME_WIDTH + 1) / 2;
   localparam int HALF_H     = (FRAME_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);
   localparam int CH_HALF_W  = $clog2(HALF_W);
   localparam int RH_W       = $clog2(HALF_H);
   localparam int SB         = SUBPIXEL_BITS;
   localparam int SH         = 32 - SB;
   localparam int MH_W       = M_W - SH;
   localparam int TMH_W      = T_W + MH_W;
   localparam int TML_W      = T_W + SH + 1;
   localparam int LO_W       = TML_W - SH;
   localparam int SX_W       = TMH_W + 2;
   localparam int XI_W       = SX_W - SB;
   localparam int FR_W       = SB + 1;
   localparam int W_W        = 2 * SB + 1;
   localparam int PROD_W     = CH_W + W_W;
   localparam int SUM_W      = PROD_W + 2;

   localparam logic signed [TML_W-1:0] TML_RND = TML_W'(1) << (SH - 1);
   localparam logic [FR_W-1:0]         F_VAL   = FR_W'(1) << SB;
   localparam logic [SUM_W-1:0]        SUM_RND = SUM_W'(1) << (2 * SB - 1);
   localparam logic signed [XI_W-1:0]  FW_S    = XI_W'(FRAME_WIDTH);
   localparam logic signed [XI_W-1:0]  FH_S    = XI_W'(FRAME_HEIGHT);

   // ---------------------------------------------------------------- registers
   logic signed [GAIN_W-1:0] gain_x_ff, gain_y_ff;
   logic [X_W-1:0]           cx_ff, aw_ff;
   logic [Y_W-1:0]           cy_ff, ah_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff <= GAIN_X_RST;
         gain_y_ff <= GAIN_Y_RST;
         cx_ff     <= CENTER_X_RST;
         cy_ff     <= CENTER_Y_RST;
         aw_ff     <= ACTIVE_W_RST;
         ah_ff     <= ACTIVE_H_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_X:        gain_x_ff <= csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_Y:        gain_y_ff <= csr_wr_data[GAIN_W-1:0];
            CSR_CENTER_X:      cx_ff     <= csr_wr_data[X_W-1:0];
            CSR_CENTER_Y:      cy_ff     <= csr_wr_data[Y_W-1:0];
            CSR_ACTIVE_WIDTH:  aw_ff     <= csr_wr_data[X_W-1:0];
            CSR_ACTIVE_HEIGHT: ah_ff     <= csr_wr_data[Y_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- pipeline
   logic adv;
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff, out_valid_in;

   // The whole pipeline moves together; it halts only while the skid holds a result.
   assign adv            = !skid_valid_ff;
   assign req_chan.ready = adv;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;
   logic s1_req_ff, s2_req_ff, s3_req_ff, s4_req_ff, s5_req_ff;
   logic s6_req_ff, s7_req_ff, s8_req_ff, s9_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   // Position and pixel payload follows each item down the pipe.
   logic [X_W-1:0]   s1_x_ff, s2_x_ff, s3_x_ff, s4_x_ff, s5_x_ff, s6_x_ff, s7_x_ff;
   logic [X_W-1:0]   s8_x_ff, s9_x_ff;
   logic [Y_W-1:0]   s1_y_ff, s2_y_ff, s3_y_ff, s4_y_ff, s5_y_ff, s6_y_ff, s7_y_ff;
   logic [Y_W-1:0]   s8_y_ff, s9_y_ff;
   logic [PIX_W-1:0] s1_pix_ff, s2_pix_ff, s3_pix_ff, s4_pix_ff, s5_pix_ff;
   logic [PIX_W-1:0] s6_pix_ff, s7_pix_ff;

   // Stage 1 to 2: offsets from the center and their squares.
   logic signed [T_W-1:0]     tx_c, ty_c;
   logic signed [2*T_W-1:0]   sqx_c, sqy_c;
   logic signed [T_W-1:0]     s2_tx_ff, s2_ty_ff, s3_tx_ff, s3_ty_ff;
   logic signed [T_W-1:0]     s4_tx_ff, s4_ty_ff;
   logic [RT_W-1:0]           s2_sqx_ff, s2_sqy_ff, s3_rt_ff;

   assign tx_c  = $signed({1'b0, s1_x_ff}) - $signed({1'b0, cx_ff});
   assign ty_c  = $signed({2'b00, s1_y_ff}) - $signed({2'b00, cy_ff});
   assign sqx_c = tx_c * tx_c;
   assign sqy_c = ty_c * ty_c;

   // Stage 4: k * rt; stage 5: t * (1 + k*rt) split at the subpixel point.
   logic signed [M_W-1:0]     kx_c, ky_c, s4_kx_ff, s4_ky_ff;
   logic signed [M_W-1:0]     mx_c, my_c;
   logic signed [TMH_W-1:0]   tmhx_c, tmhy_c, s5_tmhx_ff, s5_tmhy_ff;
   logic signed [TML_W-1:0]   tmlx_c, tmly_c, s5_tmlx_ff, s5_tmly_ff;

   assign kx_c   = gain_x_ff * $signed({1'b0, s3_rt_ff});
   assign ky_c   = gain_y_ff * $signed({1'b0, s3_rt_ff});
   assign mx_c   = s4_kx_ff + M_ONE;
   assign my_c   = s4_ky_ff + M_ONE;
   assign tmhx_c = s4_tx_ff * $signed(mx_c[M_W-1:SH]);
   assign tmhy_c = s4_ty_ff * $signed(my_c[M_W-1:SH]);
   assign tmlx_c = s4_tx_ff * $signed({1'b0, mx_c[SH-1:0]});
   assign tmly_c = s4_ty_ff * $signed({1'b0, my_c[SH-1:0]});

   // Stage 6: source position in subpixel units, rounded half up.
   logic signed [TML_W-1:0] tmlrx_c, tmlry_c;
   logic signed [LO_W-1:0]  lox_c, loy_c;
   logic signed [SX_W-1:0]  sx_c, sy_c, s6_sx_ff, s6_sy_ff;

   assign tmlrx_c = s5_tmlx_ff + TML_RND;
   assign tmlry_c = s5_tmly_ff + TML_RND;
   assign lox_c   = tmlrx_c[TML_W-1:SH];
   assign loy_c   = tmlry_c[TML_W-1:SH];
   assign sx_c = {{(SX_W-TMH_W){s5_tmhx_ff[TMH_W-1]}}, s5_tmhx_ff}
               + {{(SX_W-LO_W){lox_c[LO_W-1]}}, lox_c}
               + {{(SX_W-X_W-SB){1'b0}}, cx_ff, {SB{1'b0}}};
   assign sy_c = {{(SX_W-TMH_W){s5_tmhy_ff[TMH_W-1]}}, s5_tmhy_ff}
               + {{(SX_W-LO_W){loy_c[LO_W-1]}}, loy_c}
               + {{(SX_W-Y_W-SB){1'b0}}, cy_ff, {SB{1'b0}}};

   // Stage 6 to 7: per parity the neighbour column and row, bounds and weights.
   logic signed [XI_W-1:0] x0_c, y0_c, aw_s, ah_s;
   logic [FR_W-1:0]        fx_c, fy_c;
   logic signed [XI_W-1:0] col_sel [0:1];
   logic signed [XI_W-1:0] row_sel [0:1];
   logic [1:0]             col_ok, row_ok;
   logic [FR_W-1:0]        wx_c [0:1];
   logic [FR_W-1:0]        wy_c [0:1];
   logic [2*FR_W-1:0]      wprod_c [0:3];
   logic [CH_HALF_W-1:0]   s7_colh_ff [0:1];
   logic [RH_W-1:0]        s7_rowh_ff [0:1];
   logic [W_W-1:0]         s7_wgt_ff [0:3];
   logic [W_W-1:0]         s8_wgt_ff [0:3];
   logic [3:0]             s7_hit_ff, s8_hit_ff;

   assign x0_c = s6_sx_ff[SX_W-1:SB];
   assign y0_c = s6_sy_ff[SX_W-1:SB];
   assign fx_c = {1'b0, s6_sx_ff[SB-1:0]};
   assign fy_c = {1'b0, s6_sy_ff[SB-1:0]};
   assign aw_s = $signed({{(XI_W-X_W){1'b0}}, aw_ff});
   assign ah_s = $signed({{(XI_W-Y_W){1'b0}}, ah_ff});

   for (genvar p = 0; p < 2; p++) begin : g_par
      assign col_sel[p] = (x0_c[0] == 1'(p)) ? x0_c : x0_c + XI_W'(1);
      assign row_sel[p] = (y0_c[0] == 1'(p)) ? y0_c : y0_c + XI_W'(1);
      assign col_ok[p]  = (col_sel[p] >= 0) && (col_sel[p] < aw_s) && (col_sel[p] < FW_S);
      assign row_ok[p]  = (row_sel[p] >= 0) && (row_sel[p] < ah_s) && (row_sel[p] < FH_S);
      assign wx_c[p]    = (x0_c[0] == 1'(p)) ? F_VAL - fx_c : fx_c;
      assign wy_c[p]    = (y0_c[0] == 1'(p)) ? F_VAL - fy_c : fy_c;
   end

   for (genvar b = 0; b < 4; b++) begin : g_wgt
      assign wprod_c[b] = wx_c[b % 2] * wy_c[b / 2];
   end

   // Stage 7: bank accesses. Loads and samples use the banks at the same stage,
   // so accesses happen in acceptance order and need no forwarding.
   logic [3:0]        rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr [0:3];
   logic [ADDR_W-1:0] wr_addr;
   logic              load_in_store;
   logic [PIX_W-1:0]  rd_data [0:3];

   assign load_in_store = (32'(s7_x_ff) < FRAME_WIDTH) && (32'(s7_y_ff) < FRAME_HEIGHT);
   assign wr_addr = ADDR_W'(32'(s7_y_ff[Y_W-1:1]) * HALF_W + 32'(s7_x_ff[X_W-1:1]));

   for (genvar b = 0; b < 4; b++) begin : g_bank
      assign rd_addr[b] = ADDR_W'(32'(s7_rowh_ff[b / 2]) * HALF_W + 32'(s7_colh_ff[b % 2]));
      assign rd_en[b]   = adv && s7_valid_ff && s7_req_ff && s7_hit_ff[b];
      assign wr_en[b]   = adv && s7_valid_ff && !s7_req_ff && load_in_store
                       && ({s7_y_ff[0], s7_x_ff[0]} == 2'(b));

      rdm_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en[b]),
         .wr_addr (wr_addr),
         .wr_data (s7_pix_ff),
         .rd_en   (rd_en[b]),
         .rd_addr (rd_addr[b]),
         .rd_data (rd_data[b])
      );
   end

   // Stage 8 to 9: weighted channels; stage 9 to output: sum and round.
   logic [PROD_W-1:0] prod_c [0:3][0:2];
   logic [PROD_W-1:0] s9_prod_ff [0:3][0:2];
   logic [SUM_W-1:0]  sum_c [0:2];
   result_type        res_c, out_ff, skid_ff;

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         for (int ch = 0; ch < 3; ch++) begin
            prod_c[b][ch] = s8_hit_ff[b] ? rd_data[b][CH_W*ch +: CH_W] * s8_wgt_ff[b]
                                         : '0;
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_c[ch] = {2'b00, s9_prod_ff[0][ch]} + {2'b00, s9_prod_ff[1][ch]}
                   + {2'b00, s9_prod_ff[2][ch]} + {2'b00, s9_prod_ff[3][ch]} + SUM_RND;
      end
      res_c.x     = s9_x_ff;
      res_c.y     = s9_y_ff;
      res_c.blue  = sum_c[0][2*SB +: CH_W];
      res_c.green = sum_c[1][2*SB +: CH_W];
      res_c.red   = sum_c[2][2*SB +: CH_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_req_ff <= 1'b0;
         s2_req_ff <= 1'b0;
         s3_req_ff <= 1'b0;
         s4_req_ff <= 1'b0;
         s5_req_ff <= 1'b0;
         s6_req_ff <= 1'b0;
         s7_req_ff <= 1'b0;
         s8_req_ff <= 1'b0;
         s9_req_ff <= 1'b0;
      end else if (adv) begin
         s1_req_ff <= (req_chan.action == ACT_SAMPLE);
         s2_req_ff <= s1_req_ff;
         s3_req_ff <= s2_req_ff;
         s4_req_ff <= s3_req_ff;
         s5_req_ff <= s4_req_ff;
         s6_req_ff <= s5_req_ff;
         s7_req_ff <= s6_req_ff;
         s8_req_ff <= s7_req_ff;
         s9_req_ff <= s8_req_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff   <= req_chan.pos_x;
         s1_y_ff   <= req_chan.pos_y;
         s1_pix_ff <= {req_chan.in_red, req_chan.in_green, req_chan.in_blue};
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_pix_ff <= s1_pix_ff;
         s2_tx_ff  <= tx_c;
         s2_ty_ff  <= ty_c;
         s2_sqx_ff <= sqx_c[RT_W-1:0];
         s2_sqy_ff <= sqy_c[RT_W-1:0];
         s3_x_ff   <= s2_x_ff;
         s3_y_ff   <= s2_y_ff;
         s3_pix_ff <= s2_pix_ff;
         s3_tx_ff  <= s2_tx_ff;
         s3_ty_ff  <= s2_ty_ff;
         s3_rt_ff  <= s2_sqx_ff + s2_sqy_ff;
         s4_x_ff   <= s3_x_ff;
         s4_y_ff   <= s3_y_ff;
         s4_pix_ff <= s3_pix_ff;
         s4_tx_ff  <= s3_tx_ff;
         s4_ty_ff  <= s3_ty_ff;
         s4_kx_ff  <= kx_c;
         s4_ky_ff  <= ky_c;
         s5_x_ff    <= s4_x_ff;
         s5_y_ff    <= s4_y_ff;
         s5_pix_ff  <= s4_pix_ff;
         s5_tmhx_ff <= tmhx_c;
         s5_tmhy_ff <= tmhy_c;
         s5_tmlx_ff <= tmlx_c;
         s5_tmly_ff <= tmly_c;
         s6_x_ff   <= s5_x_ff;
         s6_y_ff   <= s5_y_ff;
         s6_pix_ff <= s5_pix_ff;
         s6_sx_ff  <= sx_c;
         s6_sy_ff  <= sy_c;
         s7_x_ff   <= s6_x_ff;
         s7_y_ff   <= s6_y_ff;
         s7_pix_ff <= s6_pix_ff;
         for (int p = 0; p < 2; p++) begin
            s7_colh_ff[p] <= col_sel[p][CH_HALF_W:1];
            s7_rowh_ff[p] <= row_sel[p][RH_W:1];
         end
         for (int b = 0; b < 4; b++) begin
            s7_wgt_ff[b] <= wprod_c[b][W_W-1:0];
            s7_hit_ff[b] <= col_ok[b % 2] && row_ok[b / 2];
            s8_wgt_ff[b] <= s7_wgt_ff[b];
            s8_hit_ff[b] <= s7_hit_ff[b];
            for (int ch = 0; ch < 3; ch++) begin
               s9_prod_ff[b][ch] <= prod_c[b][ch];
            end
         end
         s8_x_ff <= s7_x_ff;
         s8_y_ff <= s7_y_ff;
         s9_x_ff <= s8_x_ff;
         s9_y_ff <= s8_y_ff;
      end
   end

   // ---------------------------------------------------------------- output and skid
   logic res_new, take_new, take_skid, load_skid;

   assign res_new = adv && s9_valid_ff && s9_req_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      take_new      = 1'b0;
      take_skid     = 1'b0;
      load_skid     = 1'b0;
      if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            take_skid     = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (res_new) begin
         if (!out_valid_ff || rsp_chan.ready) begin
            take_new     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_new) begin
         out_ff <= res_c;
      end else if (take_skid) begin
         out_ff <= skid_ff;
      end
      if (load_skid) begin
         skid_ff <= res_c;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_x     = out_ff.x;
   assign rsp_chan.out_y     = out_ff.y;
   assign rsp_chan.out_blue  = out_ff.blue;
   assign rsp_chan.out_green = out_ff.green;
   assign rsp_chan.out_red   = out_ff.red;

   // ---------------------------------------------------------------- checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_chan.ready) |=> skid_valid_ff)
      else $error("skid item lost without being taken");

   a_bank_single_use: assert property (@(posedge clock) disable iff (reset)
      !((|rd_en) && (|wr_en)))
      else $error("banks read and written for one item");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_en))
      else $error("load item writes more than one bank");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(res_new))
      else $error("result appeared without a sample item leaving the pipeline");

endmodule

`default_nettype wire

FILE: bench/rdm_remap_checker.sv
`default_nettype none

module rdm_remap_checker import rdm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rdm_req_if                         req,
   rdm_rsp_if                         rsp,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                         mismatches,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_W = 640;
   localparam int STORE_H = 480;
   localparam int SUB     = 8;

   logic signed [GAIN_W-1:0] kx, ky;
   logic [X_W-1:0]           cx, aw;
   logic [Y_W-1:0]           cy, ah;
   logic [PIX_W-1:0]         frame_store [STORE_W*STORE_H];
   result_type               pixels_due [$];

   // Source coordinate in 1/256 pixel, rounded half up.
   function automatic longint warp(longint t, longint gain, longint rt, longint c);
      longint m, mh, ml, lo;
      m  = (64'sd1 <<< 32) + gain * rt;
      mh = m >>> (32 - SUB);
      ml = m - (mh <<< (32 - SUB));
      lo = (t * ml + (64'sd1 <<< (31 - SUB))) >>> (32 - SUB);
      return t * mh + lo + (c <<< SUB);
   endfunction

   function automatic void source_of(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                     output longint sx, output longint sy);
      longint tx, ty, rt;
      tx = longint'(x) - longint'(cx);
      ty = longint'(y) - longint'(cy);
      rt = tx * tx + ty * ty;
      sx = warp(tx, longint'(kx), rt, longint'(cx));
      sy = warp(ty, longint'(ky), rt, longint'(cy));
   endfunction

   function automatic bit in_active(longint col, longint row);
      longint wcap, hcap;
      wcap = (aw > STORE_W) ? STORE_W : aw;
      hcap = (ah > STORE_H) ? STORE_H : ah;
      return col >= 0 && col < wcap && row >= 0 && row < hcap;
   endfunction

   function automatic logic [PIX_W-1:0] pixel_at(longint col, longint row);
      if (!in_active(col, row))
         return '0;
      return frame_store[row * STORE_W + col];
   endfunction

   function automatic result_type sample_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      longint           sx, sy, x0, y0, fx, fy, acc;
      longint           w [4];
      logic [PIX_W-1:0] p [4];
      result_type       r;
      source_of(x, y, sx, sy);
      x0 = sx >>> SUB;
      y0 = sy >>> SUB;
      fx = sx - (x0 <<< SUB);
      fy = sy - (y0 <<< SUB);
      p[0] = pixel_at(x0, y0);
      p[1] = pixel_at(x0 + 1, y0);
      p[2] = pixel_at(x0, y0 + 1);
      p[3] = pixel_at(x0 + 1, y0 + 1);
      w[0] = (256 - fx) * (256 - fy);
      w[1] = fx * (256 - fy);
      w[2] = (256 - fx) * fy;
      w[3] = fx * fy;
      r.x = x;
      r.y = y;
      for (int ch = 0; ch < 3; ch++) begin
         acc = 64'sd1 <<< (2 * SUB - 1);
         for (int i = 0; i < 4; i++)
            acc += longint'(p[i][8*ch +: 8]) * w[i];
         case (ch)
            0: r.blue  = CH_W'(acc >>> (2 * SUB));
            1: r.green = CH_W'(acc >>> (2 * SUB));
            default: r.red = CH_W'(acc >>> (2 * SUB));
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         kx <= GAIN_X_RST;
         ky <= GAIN_Y_RST;
         cx <= CENTER_X_RST;
         cy <= CENTER_Y_RST;
         aw <= ACTIVE_W_RST;
         ah <= ACTIVE_H_RST;
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_GAIN_X:        kx <= csr_wr_data;
               CSR_GAIN_Y:        ky <= csr_wr_data;
               CSR_CENTER_X:      cx <= csr_wr_data[X_W-1:0];
               CSR_CENTER_Y:      cy <= csr_wr_data[Y_W-1:0];
               CSR_ACTIVE_WIDTH:  aw <= csr_wr_data[X_W-1:0];
               CSR_ACTIVE_HEIGHT: ah <= csr_wr_data[Y_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (action_type'(req.action) == ACT_LOAD) begin
               if (req.pos_x < STORE_W && req.pos_y < STORE_H)
                  frame_store[req.pos_y * STORE_W + req.pos_x] =
                     {req.in_red, req.in_green, req.in_blue};
            end else begin
               pixels_due.push_back(sample_pixel(req.pos_x, req.pos_y));
            end
         end
         if (rsp.valid && rsp.ready) begin
            got.x     = rsp.out_x;
            got.y     = rsp.out_y;
            got.blue  = rsp.out_blue;
            got.green = rsp.out_green;
            got.red   = rsp.out_red;
            if (pixels_due.size() == 0) begin
               $error("result (%0d,%0d) arrived with no pixel pending", got.x, got.y);
               mismatches <= mismatches + 1;
            end else begin
               want = pixels_due.pop_front();
               if (got != want) begin
                  if (got.x != want.x)
                     $error("out_x expected %0d got %0d", want.x, got.x);
                  if (got.y != want.y)
                     $error("out_y expected %0d got %0d", want.y, got.y);
                  if (got.blue != want.blue)
                     $error("out_blue expected %0d got %0d", want.blue, got.blue);
                  if (got.green != want.green)
                     $error("out_green expected %0d got %0d", want.green, got.green);
                  if (got.red != want.red)
                     $error("out_red expected %0d got %0d", want.red, got.red);
                  mismatches <= mismatches + 1;
               end
            end
         end
         outstanding <= pixels_due.size();
      end
   end

endmodule

`default_nettype wire

FILE: bench/radial_distortion_remap_top_tb.sv
`default_nettype none

module radial_distortion_remap_top_tb import rdm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_W     = 640;
   localparam int STORE_H     = 480;
   localparam int CYCLE_LIMIT = 600000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    mismatches, outstanding;
   int                    cycle_count;
   int                    send_idle_pct, recv_idle_pct;
   int                    holdoff_left;
   int                    items_sent;
   int                    seg_end;
   bit                    loaded [STORE_W*STORE_H];

   rdm_req_if req_if ();
   rdm_rsp_if rsp_if ();

   radial_distortion_remap_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rdm_remap_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off now and then so the
   // pipeline backs up into the input.
   initial begin
      rsp_if.ready = 1'b0;
      holdoff_left = 0;
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
         end else if (cycle_count % 5000 == 2500) begin
            holdoff_left = 300;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send(action_type act, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                       logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.action   <= act;
      req_if.pos_x    <= x;
      req_if.pos_y    <= y;
      req_if.in_blue  <= b;
      req_if.in_green <= g;
      req_if.in_red   <= r;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic load_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                             logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r);
      if (x < STORE_W && y < STORE_H)
         loaded[y * STORE_W + x] = 1'b1;
      send(ACT_LOAD, x, y, b, g, r);
   endtask

   // Loads any neighbour inside the active frame that was never written,
   // then asks for the output pixel.
   task automatic sample_at(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      longint sx, sy, col, row;
      chk.source_of(x, y, sx, sy);
      for (int n = 0; n < 4; n++) begin
         col = (sx >>> 8) + (n % 2);
         row = (sy >>> 8) + (n / 2);
         if (chk.in_active(col, row) && !loaded[row * STORE_W + col])
            load_pixel(X_W'(col), Y_W'(row), CH_W'($urandom), CH_W'($urandom),
                       CH_W'($urandom));
      end
      send(ACT_SAMPLE, x, y, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] gx, logic [31:0] gy, logic [X_W-1:0] cx,
                             logic [Y_W-1:0] cy, logic [X_W-1:0] aw, logic [Y_W-1:0] ah);
      logic [31:0] vals [6];
      vals = '{gx, gy, 32'(cx), 32'(cy), 32'(aw), 32'(ah)};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= csr_index_type'(i);
         csr_wr_data <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return $urandom;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(16000)) - 8000);
      endcase
   endfunction

   function automatic logic [X_W-1:0] pick_width();
      case ($urandom_range(9))
         0: return X_W'(1023);
         1: return X_W'(0);
         default: return X_W'($urandom_range(1, 640));
      endcase
   endfunction

   function automatic logic [Y_W-1:0] pick_height();
      case ($urandom_range(9))
         0: return Y_W'(511);
         1: return Y_W'(1);
         default: return Y_W'($urandom_range(1, 480));
      endcase
   endfunction

   task automatic random_item();
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      x = ($urandom_range(9) == 0) ? X_W'($urandom) : X_W'($urandom_range(639));
      y = ($urandom_range(9) == 0) ? Y_W'($urandom) : Y_W'($urandom_range(479));
      if ($urandom_range(99) < 25)
         load_pixel(x, y, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      else
         sample_at(x, y);
   endtask

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wr_data     = '0;
      req_if.valid    = 1'b0;
      req_if.action   = ACT_LOAD;
      req_if.pos_x    = '0;
      req_if.pos_y    = '0;
      req_if.in_blue  = '0;
      req_if.in_green = '0;
      req_if.in_red   = '0;
      items_sent      = 0;
      send_idle_pct   = 16;
      recv_idle_pct   = 74;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from the reset values of the registers.
      load_pixel(10'd0, 9'd0, 8'hFF, 8'h00, 8'hFF);
      load_pixel(10'd1, 9'd0, 8'h00, 8'hFF, 8'h00);
      load_pixel(10'd0, 9'd1, 8'hFF, 8'hFF, 8'hFF);
      load_pixel(10'd1, 9'd1, 8'h00, 8'h00, 8'h00);
      load_pixel(10'd1023, 9'd511, 8'hAA, 8'h55, 8'hAA);
      load_pixel(10'd640, 9'd0, 8'h55, 8'hAA, 8'h55);
      sample_at(10'd0, 9'd0);
      sample_at(10'd319, 9'd479);
      sample_at(10'd1023, 9'd511);
      drain();
      write_regs(32'h7FFF_FFFF, 32'h8000_0000, 10'd0, 9'd0, 10'd1023, 9'd511);
      sample_at(10'd639, 9'd479);
      sample_at(10'd0, 9'd0);
      sample_at(10'd5, 9'd3);
      drain();
      write_regs(32'h8000_0000, 32'h7FFF_FFFF, 10'd639, 9'd479, 10'd0, 9'd1);
      sample_at(10'd10, 9'd10);
      sample_at(10'd639, 9'd0);
      drain();
      write_regs(-32'sd3000, 32'sd5000, 10'd320, 9'd240, 10'd640, 9'd480);
      sample_at(10'd0, 9'd0);
      sample_at(10'd639, 9'd479);
      sample_at(10'd320, 9'd240);
      sample_at(10'd100, 9'd50);
      sample_at(10'd639, 9'd0);

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 74 : 0;
         recv_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 16 : 0;
         for (int s = 0; s < 3; s++) begin
            drain();
            write_regs(pick_gain(), pick_gain(), X_W'($urandom_range(639)),
                       Y_W'($urandom_range(479)), pick_width(), pick_height());
            // Each segment sends about 200 items, loads of neighbours included.
            seg_end = items_sent + 200;
            while (items_sent < seg_end)
               random_item();
         end
      end

      drain();
      if (mismatches == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
hdl/rdm_pkg.sv
hdl/rdm_req_if.sv
hdl/rdm_rsp_if.sv
hdl/rdm_ram.sv
hdl/radial_distortion_remap_top.sv
bench/rdm_remap_checker.sv
bench/radial_distortion_remap_top_tb.sv
